[rtl/core/sle_pkg.sv]
package sle_pkg;

  localparam int CAPACITY = 32;
  localparam int ADDR_W   = $clog2(CAPACITY);
  localparam int LEN_W    = 6;
  localparam int WORD_W   = 32;
  localparam int CMD_W    = 3;
  localparam int ST_W     = 2;
  localparam int IN_W     = 48;
  localparam int OUT_W    = 48;

  typedef enum logic [CMD_W-1:0] {
    CMD_APPEND = 3'd0,
    CMD_DROP   = 3'd1,
    CMD_INSERT = 3'd2,
    CMD_ERASE  = 3'd3,
    CMD_FIND   = 3'd4,
    CMD_DUMP   = 3'd5
  } cmd_t;

  typedef enum logic [ST_W-1:0] {
    ST_OK      = 2'd0,
    ST_RANGE   = 2'd1,
    ST_FULL    = 2'd2,
    ST_MISSING = 2'd3
  } status_t;

  typedef struct packed {
    logic            load_in;
    logic            init_walk;
    logic            rd_en;
    logic            step;
    logic            shift_wr;
    logic            put_wr;
    logic            cnt_inc;
    logic            cnt_dec;
    logic            find_hit;
    logic            emit_dump;
    logic            emit_final;
    status_t         st;
  } sle_ctl_t;

  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic             full;
    logic             empty;
    logic             pos_gt_cnt;
    logic             pos_ge_cnt;
    logic             walk_done;
    logic             match;
    logic             out_free;
  } sle_stat_t;

endpackage

[rtl/core/sle_ram.sv]
module sle_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[rtl/core/sle_ctrl.sv]
module sle_ctrl
  import sle_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_tvalid,
  output logic      in_tready,
  input  sle_stat_t stat,
  output sle_ctl_t  ctl
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_WALK,
    S_USE,
    S_FIN
  } state_t;

  state_t  state_r, state_nxt;
  status_t st_r, st_nxt;

  assign in_tready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    st_nxt    = st_r;
    ctl       = '0;
    ctl.st    = st_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          ctl.load_in = 1'b1;
          state_nxt   = S_DECODE;
        end
      end
      S_DECODE: begin
        state_nxt = S_FIN;
        st_nxt    = ST_OK;
        case (stat.cmd)
          CMD_APPEND: begin
            if (stat.full) begin
              st_nxt = ST_FULL;
            end else begin
              ctl.put_wr  = 1'b1;
              ctl.cnt_inc = 1'b1;
            end
          end
          CMD_DROP: begin
            ctl.cnt_dec = !stat.empty;
          end
          CMD_INSERT: begin
            priority if (stat.pos_gt_cnt) begin
              st_nxt = ST_RANGE;
            end else if (stat.full) begin
              st_nxt = ST_FULL;
            end else begin
              ctl.init_walk = 1'b1;
              state_nxt     = S_WALK;
            end
          end
          CMD_ERASE: begin
            if (stat.pos_ge_cnt) begin
              st_nxt = ST_RANGE;
            end else begin
              ctl.init_walk = 1'b1;
              state_nxt     = S_WALK;
            end
          end
          CMD_FIND, CMD_DUMP: begin
            ctl.init_walk = 1'b1;
            state_nxt     = S_WALK;
          end
          default: begin
            st_nxt = ST_OK;
          end
        endcase
      end
      S_WALK: begin
        if (stat.walk_done) begin
          state_nxt = S_FIN;
          case (stat.cmd)
            CMD_INSERT: begin
              ctl.put_wr  = 1'b1;
              ctl.cnt_inc = 1'b1;
            end
            CMD_ERASE: begin
              ctl.cnt_dec = 1'b1;
            end
            CMD_FIND: begin
              st_nxt = ST_MISSING;
            end
            default: begin
              state_nxt = S_IDLE;
            end
          endcase
        end else begin
          ctl.rd_en = 1'b1;
          state_nxt = S_USE;
        end
      end
      S_USE: begin
        case (stat.cmd)
          CMD_FIND: begin
            if (stat.match) begin
              ctl.find_hit = 1'b1;
              state_nxt    = S_FIN;
            end else begin
              ctl.step  = 1'b1;
              state_nxt = S_WALK;
            end
          end
          CMD_DUMP: begin
            if (stat.out_free) begin
              ctl.emit_dump = 1'b1;
              ctl.step      = 1'b1;
              state_nxt     = S_WALK;
            end
          end
          default: begin
            ctl.shift_wr = 1'b1;
            ctl.step     = 1'b1;
            state_nxt    = S_WALK;
          end
        endcase
      end
      S_FIN: begin
        if (stat.out_free) begin
          ctl.emit_final = 1'b1;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      st_r    <= ST_OK;
    end else begin
      state_r <= state_nxt;
      st_r    <= st_nxt;
    end
  end

  a_emit_needs_slot: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl.emit_dump || ctl.emit_final) |-> stat.out_free)
    else $error("result loaded while output register is occupied");

  a_accept_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.load_in |=> (state_r == S_DECODE))
    else $error("accepted word not decoded next cycle");

  a_write_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    !(ctl.shift_wr && ctl.put_wr))
    else $error("shift and put write in the same cycle");

endmodule

[rtl/core/sle_dpath.sv]
module sle_dpath
  import sle_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic [IN_W-1:0]  in_tdata,
  input  sle_ctl_t         ctl,
  output sle_stat_t        stat,
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [OUT_W-1:0] out_tdata,
  output logic             out_tlast
);

  logic [CMD_W-1:0]  cmd_r;
  logic [LEN_W-1:0]  pos_r;
  logic [WORD_W-1:0] val_r;
  logic [LEN_W-1:0]  count_r, count_nxt;
  logic [LEN_W-1:0]  ptr_r, ptr_nxt;
  logic [ADDR_W-1:0] hit_idx_r;

  logic              out_valid_r;
  logic [ST_W-1:0]   out_status_r;
  logic [ADDR_W-1:0] out_index_r;
  logic [WORD_W-1:0] out_element_r;
  logic [LEN_W-1:0]  out_length_r;
  logic              out_last_r;

  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [WORD_W-1:0] ram_wdata;
  logic [LEN_W-1:0]  raddr_full;
  logic [WORD_W-1:0] ram_rdata;
  logic [ADDR_W-1:0] put_addr;
  logic [LEN_W:0]    ptr_plus1;
  logic              dump_last;

  assign ptr_plus1 = {1'b0, ptr_r} + (LEN_W+1)'(1);
  assign dump_last = (ptr_plus1 == {1'b0, count_r});

  always_comb begin
    case (cmd_r)
      CMD_INSERT: raddr_full = ptr_r - LEN_W'(1);
      CMD_ERASE:  raddr_full = ptr_r + LEN_W'(1);
      default:    raddr_full = ptr_r;
    endcase
  end

  assign put_addr  = (cmd_r == CMD_APPEND) ? count_r[ADDR_W-1:0] : pos_r[ADDR_W-1:0];
  assign ram_we    = ctl.shift_wr || ctl.put_wr;
  assign ram_waddr = ctl.put_wr ? put_addr : ptr_r[ADDR_W-1:0];
  assign ram_wdata = ctl.put_wr ? val_r : ram_rdata;

  sle_ram #(
    .WIDTH (WORD_W),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ctl.rd_en),
    .raddr (raddr_full[ADDR_W-1:0]),
    .rdata (ram_rdata)
  );

  always_comb begin
    stat.cmd        = cmd_r;
    stat.full       = (count_r == LEN_W'(CAPACITY));
    stat.empty      = (count_r == '0);
    stat.pos_gt_cnt = (pos_r > count_r);
    stat.pos_ge_cnt = (pos_r >= count_r);
    stat.match      = (ram_rdata == val_r);
    stat.out_free   = !out_valid_r || out_tready;
    case (cmd_r)
      CMD_INSERT:         stat.walk_done = (ptr_r == pos_r);
      CMD_ERASE:          stat.walk_done = (ptr_plus1 >= {1'b0, count_r});
      CMD_FIND, CMD_DUMP: stat.walk_done = (ptr_r >= count_r);
      default:            stat.walk_done = 1'b1;
    endcase
  end

  always_comb begin
    count_nxt = count_r;
    if (ctl.cnt_inc) begin
      count_nxt = count_r + LEN_W'(1);
    end else if (ctl.cnt_dec) begin
      count_nxt = count_r - LEN_W'(1);
    end
  end

  always_comb begin
    ptr_nxt = ptr_r;
    if (ctl.init_walk) begin
      case (cmd_r)
        CMD_INSERT: ptr_nxt = count_r;
        CMD_ERASE:  ptr_nxt = pos_r;
        default:    ptr_nxt = '0;
      endcase
    end else if (ctl.step) begin
      ptr_nxt = (cmd_r == CMD_INSERT) ? ptr_r - LEN_W'(1) : ptr_r + LEN_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      if (ctl.emit_dump || ctl.emit_final) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    ptr_r <= ptr_nxt;
    if (ctl.load_in) begin
      cmd_r     <= in_tdata[CMD_W-1:0];
      pos_r     <= in_tdata[CMD_W +: LEN_W];
      val_r     <= in_tdata[CMD_W+LEN_W +: WORD_W];
      hit_idx_r <= '0;
    end else if (ctl.find_hit) begin
      hit_idx_r <= ptr_r[ADDR_W-1:0];
    end
    if (ctl.emit_dump) begin
      out_status_r  <= ST_OK;
      out_index_r   <= ptr_r[ADDR_W-1:0];
      out_element_r <= ram_rdata;
      out_length_r  <= count_r;
      out_last_r    <= dump_last;
    end else if (ctl.emit_final) begin
      out_status_r  <= ctl.st;
      out_index_r   <= hit_idx_r;
      out_element_r <= '0;
      out_length_r  <= count_r;
      out_last_r    <= 1'b1;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {{(OUT_W-ST_W-ADDR_W-WORD_W-LEN_W){1'b0}},
                       out_length_r, out_element_r, out_index_r, out_status_r};

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= LEN_W'(CAPACITY))
    else $error("length beyond capacity");

  a_inc_not_full: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.cnt_inc |-> !stat.full)
    else $error("length raised on a full list");

  a_dec_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.cnt_dec |-> !stat.empty)
    else $error("length lowered on an empty list");

endmodule

[rtl/core/sequential_list_engine.sv]
// Sequential list engine: an ordered list of up to 32 signed 32-bit words.
// Input channel (in_*): one word per command; tdata holds command, position
// and value. The engine takes a word only when idle, one command at a time.
// Result channel (out_*): status, index, element and length in tdata, with
// tlast on the final result of a command. Dump gives one result per entry
// (none for an empty list); every other command gives exactly one result.
// Append, drop last and unused codes give their result without a walk.
// Insert, erase, find and dump walk the store through one memory read port,
// reading each entry in a WALK state and using it in a USE state: insert
// visits length-position entries, erase length-position-1, find up to and
// including the match, dump all entries. The next word is taken only after
// the final result is loaded. A held-off receiver stalls a dump walk and the
// final result: the engine keeps one result in its output register and
// waits before loading the next.
// Reset (rst_n low, synchronous) empties the list and drops any pending
// result; the store itself is not cleared, since only written entries are read.
module sequential_list_engine
  import sle_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic [IN_W-1:0]  in_tdata,   // command[2:0], position[8:3], value[40:9], zero
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [OUT_W-1:0] out_tdata,  // status[1:0], index[6:2], element[38:7],
                                       // length[44:39], zero
  output logic             out_tlast
);

  sle_ctl_t  ctl;
  sle_stat_t stat;

  sle_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (stat),
    .ctl       (ctl)
  );

  sle_dpath u_dpath (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .ctl        (ctl),
    .stat       (stat),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule
